// File: rtl/awm_pkg.sv
// Package for the Accept-header image/webp matcher.
// Parser phase types, character constants and per-byte helper functions.
// Used by awm_parser and accept_header_webp_match.
package awm_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CountW   = 4;
  localparam logic [CountW-1:0] MediaLen = 4'd10;

  localparam logic [ByteW-1:0] ChComma = 8'h2C;  // ','
  localparam logic [ByteW-1:0] ChSemi  = 8'h3B;  // ';'
  localparam logic [ByteW-1:0] ChEq    = 8'h3D;  // '='
  localparam logic [ByteW-1:0] ChLq    = 8'h71;  // 'q'
  localparam logic [ByteW-1:0] ChUq    = 8'h51;  // 'Q'
  localparam logic [ByteW-1:0] ChOne   = 8'h31;  // '1'
  localparam logic [ByteW-1:0] ChZero  = 8'h30;  // '0'
  localparam logic [ByteW-1:0] ChNine  = 8'h39;  // '9'
  localparam logic [ByteW-1:0] ChDot   = 8'h2E;  // '.'

  // Position inside one comma-separated item
  typedef enum logic [3:0] {
    PhLead   = 4'd0,
    PhMedia  = 4'd1,
    PhTail   = 4'd2,
    PhSkip   = 4'd3,
    PhPlead  = 4'd4,
    PhPq     = 4'd5,
    PhPother = 4'd6,
    PhPvalue = 4'd7
  } parse_phase_e;

  // Position inside a q value
  typedef enum logic [2:0] {
    QvStart   = 3'd0,
    QvOne     = 3'd1,
    QvOneDot  = 3'd2,
    QvZero    = 3'd3,
    QvDigits  = 3'd4,
    QvTrailOk = 3'd5,
    QvFail    = 3'd6
  } qv_phase_e;

  typedef struct packed {
    qv_phase_e phase;
    logic      digit_seen;
    logic      saw_nonzero;
  } q_state_t;

  localparam q_state_t QStateReset = '{phase: QvStart, digit_seen: 1'b0, saw_nonzero: 1'b0};

  function automatic logic is_ws(input logic [ByteW-1:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_dig(input logic [ByteW-1:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic [ByteW-1:0] to_lower(input logic [ByteW-1:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) ? c + 8'd32 : c;
  endfunction

  // Characters of "image/webp"
  function automatic logic [ByteW-1:0] media_char(input logic [CountW-1:0] idx);
    logic [ByteW-1:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h69;  // i
      4'd1:    ch = 8'h6D;  // m
      4'd2:    ch = 8'h61;  // a
      4'd3:    ch = 8'h67;  // g
      4'd4:    ch = 8'h65;  // e
      4'd5:    ch = 8'h2F;  // /
      4'd6:    ch = 8'h77;  // w
      4'd7:    ch = 8'h65;  // e
      4'd8:    ch = 8'h62;  // b
      4'd9:    ch = 8'h70;  // p
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic q_verdict(input q_state_t q);
    logic ok;
    case (q.phase)
      QvOne:     ok = 1'b1;
      QvOneDot:  ok = q.digit_seen;
      QvDigits:  ok = q.digit_seen & q.saw_nonzero;
      QvTrailOk: ok = 1'b1;
      default:   ok = 1'b0;
    endcase
    return ok;
  endfunction

  // Advance the q value parser by one character
  function automatic q_state_t q_feed(input q_state_t q, input logic [ByteW-1:0] c);
    q_state_t n;
    n = q;
    if (is_ws(c)) begin
      if ((q.phase != QvStart) && (q.phase != QvTrailOk) && (q.phase != QvFail)) begin
        n.phase = q_verdict(q) ? QvTrailOk : QvFail;
      end
    end else begin
      case (q.phase)
        QvStart: begin
          if (c == ChOne)       n.phase = QvOne;
          else if (c == ChZero) n.phase = QvZero;
          else if (c == ChDot)  n.phase = QvDigits;
          else                  n.phase = QvFail;
        end
        QvOne: n.phase = (c == ChDot) ? QvOneDot : QvFail;
        QvOneDot: begin
          if (c == ChZero) n.digit_seen = 1'b1;
          else             n.phase = QvFail;
        end
        QvZero, QvDigits: begin
          if ((q.phase == QvZero) && (c == ChDot)) begin
            n.phase = QvDigits;
          end else if (is_dig(c)) begin
            n.phase      = QvDigits;
            n.digit_seen = 1'b1;
            if (c != ChZero) n.saw_nonzero = 1'b1;
          end else begin
            n.phase = QvFail;
          end
        end
        default: n.phase = QvFail;
      endcase
    end
    return n;
  endfunction

  // True when closing the current item counts as an accepted image/webp
  function automatic logic item_hit(input parse_phase_e ph, input logic [CountW-1:0] mc,
                                    input logic allowed, input q_state_t q);
    logic hit;
    case (ph)
      PhMedia:                    hit = (mc == MediaLen) & allowed;
      PhTail, PhPlead, PhPq,
      PhPother:                   hit = allowed;
      PhPvalue:                   hit = q_verdict(q);
      default:                    hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// File: rtl/awm_parser.sv
// Byte-wise parser state for the Accept-header image/webp matcher.
// Holds item, q-value and found state; depends on awm_pkg.
module awm_parser import awm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,     // consume byte_i this cycle
  input  logic [ByteW-1:0] byte_i,
  input  logic             last_i,
  output logic             accepted_o  // verdict if byte_i is the last byte
);

  parse_phase_e      phase_q, phase_d;
  logic [CountW-1:0] count_q, count_d;
  logic              found_q, found_d;
  logic              allowed_q, allowed_d;
  q_state_t          qst_q, qst_d;
  logic [ByteW-1:0]  low_c;

  assign low_c = to_lower(byte_i);

  // Next state for one byte, then close the header on the last byte
  always_comb begin
    phase_d   = phase_q;
    count_d   = count_q;
    found_d   = found_q;
    allowed_d = allowed_q;
    qst_d     = qst_q;

    if (byte_i == ChComma) begin
      if (item_hit(phase_q, count_q, allowed_q, qst_q)) found_d = 1'b1;
      phase_d   = PhLead;
      count_d   = '0;
      allowed_d = 1'b1;
      qst_d     = QStateReset;
    end else begin
      unique case (phase_q)
        PhLead: begin
          if (!is_ws(byte_i)) begin
            if (low_c == media_char('0)) begin
              phase_d = PhMedia;
              count_d = 4'd1;
            end else begin
              phase_d = PhSkip;
            end
          end
        end
        PhMedia: begin
          if (count_q >= MediaLen) begin
            if (is_ws(byte_i))        phase_d = PhTail;
            else if (byte_i == ChSemi) phase_d = PhPlead;
            else                       phase_d = PhSkip;
          end else if (low_c == media_char(count_q)) begin
            count_d = count_q + 4'd1;
          end else begin
            phase_d = PhSkip;
          end
        end
        PhTail: begin
          if (!is_ws(byte_i)) phase_d = (byte_i == ChSemi) ? PhPlead : PhSkip;
        end
        PhPlead: begin
          if (!is_ws(byte_i) && (byte_i != ChSemi)) begin
            phase_d = ((byte_i == ChLq) || (byte_i == ChUq)) ? PhPq : PhPother;
          end
        end
        PhPq: begin
          if (byte_i == ChEq) begin
            phase_d = PhPvalue;
            qst_d   = QStateReset;
          end else begin
            phase_d = (byte_i == ChSemi) ? PhPlead : PhPother;
          end
        end
        PhPother: begin
          if (byte_i == ChSemi) phase_d = PhPlead;
        end
        PhPvalue: begin
          if (byte_i == ChSemi) begin
            allowed_d = q_verdict(qst_q);
            phase_d   = PhPlead;
          end else begin
            qst_d = q_feed(qst_q, byte_i);
          end
        end
        default: phase_d = PhSkip;
      endcase
    end

    // Close the final item; the verdict leaves with this byte
    accepted_o = found_d | item_hit(phase_d, count_d, allowed_d, qst_d);

    if (last_i) begin
      phase_d   = PhLead;
      count_d   = '0;
      found_d   = 1'b0;
      allowed_d = 1'b1;
      qst_d     = QStateReset;
    end
  end

  // Advance state on each consumed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhLead;
      count_q   <= '0;
      found_q   <= 1'b0;
      allowed_q <= 1'b1;
      qst_q     <= QStateReset;
    end else if (step_i) begin
      phase_q   <= phase_d;
      count_q   <= count_d;
      found_q   <= found_d;
      allowed_q <= allowed_d;
      qst_q     <= qst_d;
    end
  end

endmodule

// File: rtl/accept_header_webp_match.sv
// Top level of the Accept-header image/webp matcher.
// Input register, awm_parser and result register; depends on awm_pkg.
//
// Usage:
//   Stream the Accept header into the slave channel one byte per transaction,
//   tlast set on the final byte. For every header exactly one transaction
//   leaves on the master channel, tdata[0] = 1 when some item names
//   image/webp (case-insensitive, trimmed) with a positive q value.
//   Bytes other than the last one produce no output transaction.
// Path: a last byte is captured in the input register, passes the
//   combinational parser update and is loaded into the result register
//   (shown on the master channel from then on).
// Throughput: one byte per cycle across headers, unless a final byte waits.
// Reset: clears the input and result valid flags and all parser state;
//   the first byte after reset starts a new header.
// Stall: a result waiting on the master side holds; non-final bytes keep
//   flowing, and only a final byte waits in the input register until the
//   result register frees; tready stays low while it waits.
module accept_header_webp_match import awm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] header_byte
  input  logic       s_axis_tlast,   // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] webp_accepted, [7:1] zero
);

  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;
  logic             out_valid_q, out_valid_d;
  logic             out_bit_q;
  logic             out_free;
  logic             in_fire;
  logic             step;
  logic             accepted;

  // Byte in the input register moves on unless it needs a busy result slot
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || step;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = in_fire ? 1'b1 : (step ? 1'b0 : in_valid_q);
  assign out_valid_d = (step && in_last_q) ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  awm_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (in_byte_q),
    .last_i     (in_last_q),
    .accepted_o (accepted)
  );

  // Input register valid and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the incoming transaction
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // Load the verdict when the final byte is consumed
  always_ff @(posedge clk_i) begin
    if (step && in_last_q) begin
      out_bit_q <= accepted;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_bit_q};

endmodule

// File: rtl/awm_checker.sv
// Port-level checks for accept_header_webp_match, bound to the top level.
// Depends only on the top level's ports.
module awm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // Keep padding bits of the result at zero
  a_out_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'd0))
    else $error("result padding not zero");

  // Input backpressure only while a result is stalled
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a stalled result");

  // An empty result slot never stalls the input
  a_in_resume: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the result slot was empty");

endmodule

bind accept_header_webp_match awm_checker u_awm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
